[rtl/sfd_pkg.sv]
package sfd_pkg;

  localparam int BUFFER_BYTES = 2048;

  localparam int BURST_CAP_INT = (BUFFER_BYTES - 2 > 2047) ? 2047 : BUFFER_BYTES - 2;
  localparam logic [10:0] BURST_CAP = BURST_CAP_INT[10:0];

  localparam logic [10:0] MAX_PAYLOAD_RESET = 11'd1518;
  localparam logic [7:0]  START_BYTE        = 8'hAA;
  localparam logic [16:0] SPI_OVERHEAD      = 17'd10;
  localparam logic [16:0] TRAILER_BYTES     = 17'd4;
  localparam logic [3:0]  HEADER_LAST       = 4'd11;

  localparam logic [3:0] IDX_SPI_HI   = 4'd2;
  localparam logic [3:0] IDX_SPI_LO   = 4'd3;
  localparam logic [3:0] IDX_START_0  = 4'd4;
  localparam logic [3:0] IDX_START_1  = 4'd5;
  localparam logic [3:0] IDX_START_2  = 4'd6;
  localparam logic [3:0] IDX_START_3  = 4'd7;
  localparam logic [3:0] IDX_ETH_LO   = 4'd8;
  localparam logic [3:0] IDX_ETH_HI   = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_OVERRUN   = 3'd3;
  localparam logic [2:0] ST_BAD_START = 3'd4;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        burst_start;
    logic [10:0] burst_length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic        last;
    logic [2:0]  status;
    logic [10:0] frame_length;
  } out_beat_t;

endpackage

[rtl/sfd_parser.sv]
module sfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  sfd_pkg::in_beat_t in_beat,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_data,
  output logic              result_valid,
  output sfd_pkg::out_beat_t result
);
  import sfd_pkg::*;

  logic [10:0] max_payload;
  logic [3:0]  hdr_index;
  logic [10:0] burst_total;
  logic [15:0] spi_length;
  logic [15:0] eth_length;
  logic        start_bytes_ok;
  logic [1:0]  phase;
  logic [10:0] payload_left;

  logic [3:0]  hdr_index_next;
  logic [10:0] burst_total_next;
  logic [15:0] spi_length_next;
  logic [15:0] eth_length_next;
  logic        start_bytes_ok_next;
  logic [1:0]  phase_next;
  logic [10:0] payload_left_next;

  logic [10:0] clip_length;
  logic [15:0] cap_length;
  logic [10:0] left_dec;
  logic        produce;
  out_beat_t   res;

  always_comb begin
    clip_length = (in_beat.burst_length > BURST_CAP) ? BURST_CAP : in_beat.burst_length;
    hdr_index_next      = in_beat.burst_start ? 4'd0 : hdr_index;
    burst_total_next    = in_beat.burst_start ? clip_length : burst_total;
    spi_length_next     = in_beat.burst_start ? 16'd0 : spi_length;
    eth_length_next     = in_beat.burst_start ? 16'd0 : eth_length;
    start_bytes_ok_next = in_beat.burst_start ? 1'b1 : start_bytes_ok;
    phase_next          = in_beat.burst_start ? PH_HEADER : phase;
    payload_left_next   = in_beat.burst_start ? 11'd0 : payload_left;
    left_dec   = payload_left_next - 11'd1;
    cap_length = (eth_length_next > {5'd0, max_payload}) ? {5'd0, max_payload}
                                                         : eth_length_next;
    produce = 1'b0;
    res     = '0;
    case (phase_next)
      PH_PAYLOAD: begin
        produce           = 1'b1;
        payload_left_next = left_dec;
        res.out_byte      = in_beat.data_byte;
        res.payload_valid = 1'b1;
        if (left_dec == 11'd0) begin
          phase_next       = PH_DONE;
          res.last         = 1'b1;
          res.frame_length = eth_length_next[10:0];
        end
      end
      PH_HEADER: begin
        case (hdr_index_next)
          IDX_SPI_HI: spi_length_next = {in_beat.data_byte, spi_length_next[7:0]};
          IDX_SPI_LO: spi_length_next = {spi_length_next[15:8], in_beat.data_byte};
          IDX_START_0, IDX_START_1, IDX_START_2, IDX_START_3: begin
            if (in_beat.data_byte != START_BYTE) start_bytes_ok_next = 1'b0;
          end
          IDX_ETH_LO: eth_length_next = {eth_length_next[15:8], in_beat.data_byte};
          IDX_ETH_HI: eth_length_next = {in_beat.data_byte, eth_length_next[7:0]};
          default: ;
        endcase
        if (hdr_index_next == HEADER_LAST) begin
          phase_next = PH_DONE;
          if ({1'b0, spi_length_next} < SPI_OVERHEAD ||
              {1'b0, eth_length_next} + SPI_OVERHEAD != {1'b0, spi_length_next}) begin
            produce = 1'b1;
            res.last = 1'b1;
            res.status = ST_MISMATCH;
          end else if ({1'b0, spi_length_next} + TRAILER_BYTES >
                       {6'd0, burst_total_next}) begin
            produce = 1'b1;
            res.last = 1'b1;
            res.status = ST_OVERRUN;
          end else if (!start_bytes_ok_next) begin
            produce = 1'b1;
            res.last = 1'b1;
            res.status = ST_BAD_START;
          end else begin
            eth_length_next = cap_length;
            if (cap_length == 16'd0) begin
              produce = 1'b1;
              res.last = 1'b1;
              res.status = ST_OK;
            end else begin
              payload_left_next = cap_length[10:0];
              phase_next = PH_PAYLOAD;
            end
          end
        end else if ({8'd0, hdr_index_next} + 12'd1 >= {1'b0, burst_total_next}) begin
          phase_next = PH_DONE;
          produce = 1'b1;
          res.last = 1'b1;
          res.status = ST_SHORT;
        end else begin
          hdr_index_next = hdr_index_next + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign result_valid = accept && produce;
  assign result       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RESET;
      hdr_index      <= 4'd0;
      burst_total    <= 11'd0;
      spi_length     <= 16'd0;
      eth_length     <= 16'd0;
      start_bytes_ok <= 1'b1;
      phase          <= PH_HEADER;
      payload_left   <= 11'd0;
    end else begin
      if (cfg_we) max_payload <= cfg_data;
      if (accept) begin
        hdr_index      <= hdr_index_next;
        burst_total    <= burst_total_next;
        spi_length     <= spi_length_next;
        eth_length     <= eth_length_next;
        start_bytes_ok <= start_bytes_ok_next;
        phase          <= phase_next;
        payload_left   <= payload_left_next;
      end
    end
  end

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_left != 11'd0)
    else $error("payload phase with nothing left");

  a_hdr_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> hdr_index <= HEADER_LAST)
    else $error("header index past header");

endmodule

[rtl/sfd_out_skid.sv]
module sfd_out_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfd_pkg::out_beat_t push_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sfd_pkg::out_beat_t out_data
);
  import sfd_pkg::*;

  logic      skid_valid;
  out_beat_t skid_data;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && push))
    else $error("skid filled without a stall");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed while skid full");

endmodule

[rtl/spi_ethernet_frame_deframer.sv]
// channel   direction  signals                      payload
// in        input      in_valid / in_ready          in_data  (data_byte, burst_start, burst_length)
// out       output     out_valid / out_ready        out_data (out_byte, payload_valid, last,
//                                                             status, frame_length)
// cfg       input      cfg_we                       cfg_data (max_payload)
//
// one input beat per cycle while in_ready is high; any result is registered in the output stage
// rst is synchronous; max_payload resets to 1518, parser returns to header phase
// a two-entry output stage (output register plus skid) keeps in_ready high through
// a single stalled output beat; in_ready drops only while the skid holds a beat
module spi_ethernet_frame_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfd_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_data
);
  import sfd_pkg::*;

  logic      accept;
  logic      result_valid;
  out_beat_t result;

  assign accept = in_valid && in_ready;

  sfd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_beat      (in_data),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  sfd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/spi_ethernet_frame_deframer_tb.sv]
module spi_ethernet_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  class deframe_scoreboard;
    logic [10:0] max_payload;
    logic [10:0] byte_index;
    logic [10:0] burst_total;
    logic [10:0] payload_left;
    logic [15:0] spi_length;
    logic [15:0] eth_length;
    logic        start_ok;
    logic [1:0]  phase;
    out_beat_t   pending_beats[$];
    int          mismatches;
    int          bytes_taken;
    int          beats_checked;
    int          frames_delivered;
    int          error_endings;

    function void reset_state();
      max_payload = MAX_PAYLOAD_RESET;
      byte_index = '0;
      burst_total = '0;
      payload_left = '0;
      spi_length = '0;
      eth_length = '0;
      start_ok = 1'b1;
      phase = PH_HEADER;
    endfunction

    function void take_byte(in_beat_t b);
      out_beat_t r;
      logic [10:0] n;
      r = '0;
      bytes_taken++;
      if (b.burst_start) begin
        byte_index = '0;
        burst_total = (b.burst_length > BURST_CAP) ? BURST_CAP : b.burst_length;
        spi_length = '0;
        eth_length = '0;
        start_ok = 1'b1;
        phase = PH_HEADER;
        payload_left = '0;
      end
      if (phase == PH_DONE) return;
      if (phase == PH_PAYLOAD) begin
        byte_index = byte_index + 11'd1;
        payload_left = payload_left - 11'd1;
        r.out_byte = b.data_byte;
        r.payload_valid = 1'b1;
        if (payload_left == '0) begin
          phase = PH_DONE;
          r.last = 1'b1;
          r.status = ST_OK;
          r.frame_length = eth_length[10:0];
        end
        pending_beats.push_back(r);
        return;
      end
      case (byte_index)
        IDX_SPI_HI: spi_length[15:8] = b.data_byte;
        IDX_SPI_LO: spi_length[7:0] = b.data_byte;
        IDX_START_0, IDX_START_1, IDX_START_2, IDX_START_3: begin
          if (b.data_byte != START_BYTE) start_ok = 1'b0;
        end
        IDX_ETH_LO: eth_length[7:0] = b.data_byte;
        IDX_ETH_HI: eth_length[15:8] = b.data_byte;
        default: ;
      endcase
      if (byte_index == HEADER_LAST) begin
        phase = PH_DONE;
        r.last = 1'b1;
        if (int'(spi_length) < int'(SPI_OVERHEAD) ||
            int'(eth_length) + int'(SPI_OVERHEAD) != int'(spi_length)) begin
          r.status = ST_MISMATCH;
        end else if (int'(spi_length) + int'(TRAILER_BYTES) > int'(burst_total)) begin
          r.status = ST_OVERRUN;
        end else if (!start_ok) begin
          r.status = ST_BAD_START;
        end else begin
          n = (int'(eth_length) > int'(max_payload)) ? max_payload : eth_length[10:0];
          eth_length = {5'd0, n};
          r.status = ST_OK;
          if (n != '0) begin
            payload_left = n;
            byte_index = 11'd12;
            phase = PH_PAYLOAD;
            return;
          end
        end
        pending_beats.push_back(r);
        return;
      end
      if (int'(byte_index) + 1 >= int'(burst_total)) begin
        phase = PH_DONE;
        r.last = 1'b1;
        r.status = ST_SHORT;
        pending_beats.push_back(r);
        return;
      end
      byte_index = byte_index + 11'd1;
    endfunction

    task report(string what, int got_v, int want_v);
      $display("beat %0d: %s got %0d, wanted %0d", beats_checked, what, got_v, want_v);
      mismatches++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      beats_checked++;
      if (got.last) begin
        if (got.status == ST_OK) frames_delivered++;
        else error_endings++;
      end
      if (pending_beats.size() == 0) begin
        report("unexpected beat, status", int'(got.status), 0);
        return;
      end
      want = pending_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        report("out_byte", int'(got.out_byte), int'(want.out_byte));
      if (got.payload_valid !== want.payload_valid)
        report("payload_valid", int'(got.payload_valid), int'(want.payload_valid));
      if (got.last !== want.last) report("last", int'(got.last), int'(want.last));
      if (got.status !== want.status) report("status", int'(got.status), int'(want.status));
      if (got.frame_length !== want.frame_length)
        report("frame_length", int'(got.frame_length), int'(want.frame_length));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;

  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;
  logic [10:0] small_cap;

  deframe_scoreboard sb = new();

  spi_ethernet_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_beat(out_data);
  end

  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        held = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_beat(logic [7:0] d, logic s, logic [10:0] len);
    in_beat_t b;
    b.data_byte = d;
    b.burst_start = s;
    b.burst_length = len;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(b);
  endtask

  task automatic send_burst(logic [10:0] blen, logic [15:0] spi, logic [15:0] eth,
                            int bad_at, int n);
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(255));
      case (i)
        IDX_SPI_HI: d = spi[15:8];
        IDX_SPI_LO: d = spi[7:0];
        IDX_START_0, IDX_START_1, IDX_START_2, IDX_START_3: d = START_BYTE;
        IDX_ETH_LO: d = eth[7:0];
        IDX_ETH_HI: d = eth[15:8];
        default: ;
      endcase
      if (i == bad_at) d = START_BYTE ^ 8'($urandom_range(1, 255));
      send_beat(d, i == 0, (i == 0) ? blen : 11'($urandom_range(2047)));
    end
  endtask

  task automatic random_burst();
    int kind;
    int eth;
    int spi;
    int blen;
    int n;
    int bad_at;
    kind = $urandom_range(99);
    eth = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(48);
    spi = eth + int'(SPI_OVERHEAD);
    blen = spi + int'(TRAILER_BYTES) + $urandom_range(3);
    n = blen;
    bad_at = -1;
    if (kind < 62) begin
      if ($urandom_range(9) == 0) n = $urandom_range(1, blen - 1);
    end else if (kind < 68) begin
      // length fields disagree
      spi = $urandom_range(16'hffff);
      eth = ($urandom_range(1) == 0) ? $urandom_range(16'hffff) : spi - 9;
      blen = $urandom_range(12, 2047);
      n = 12 + $urandom_range(3);
    end else if (kind < 72) begin
      spi = $urandom_range(9);
      eth = ($urandom_range(1) == 0) ? $urandom_range(16'hffff) : 16'hfff6 + spi;
      n = 12 + $urandom_range(3);
    end else if (kind < 78) begin
      if ($urandom_range(3) == 0) begin
        spi = 16'hffff;
        eth = 16'hfff5;
        blen = $urandom_range(12, 2047);
      end else begin
        blen = $urandom_range(12, spi + 3);
      end
      n = 12 + $urandom_range(3);
    end else if (kind < 84) begin
      bad_at = $urandom_range(4, 7);
      n = 12 + $urandom_range(3);
    end else if (kind < 92) begin
      blen = $urandom_range(11);
      n = blen + $urandom_range(3);
      if (n == 0) n = 1;
    end else begin
      repeat ($urandom_range(1, 8))
        send_beat(8'($urandom_range(255)), $urandom_range(3) == 0,
                  11'($urandom_range(2047)));
      return;
    end
    send_burst(11'(blen), 16'(spi), 16'(eth), bad_at, n);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(logic [10:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_payload = v;
  endtask

  task automatic run_random(int tx_pct, int rx_pct, int target);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sb.bytes_taken < target) random_burst();
    drain();
  endtask

  initial begin
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray byte before any burst, zero-length burst, byte after the end
    send_beat(8'h00, 1'b0, 11'h7ff);
    send_beat(8'hff, 1'b1, 11'd0);
    send_beat(8'h55, 1'b0, 11'd0);
    // burst length clipped to the buffer, so the frame overruns
    send_burst(11'h7ff, 16'h07fb, 16'h07f1, -1, 12);
    // restart mid-burst, then an empty payload frame
    send_burst(11'd1024, 16'd10, 16'd0, -1, 3);
    send_burst(11'd14, 16'd10, 16'd0, -1, 12);
    drain();

    write_max_payload(11'h7ff);
    run_random(8, 74, 200);

    write_max_payload(11'd0);
    run_random(74, 8, 370);

    small_cap = 11'($urandom_range(1, 30));
    write_max_payload(small_cap);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_cycles = 80;
    send_burst(11'd74, 16'd70, 16'd60, -1, 74);
    run_random(0, 0, 540);

    write_max_payload(MAX_PAYLOAD_RESET);
    run_random(0, 0, 720);

    repeat (10) @(posedge clk);
    $display("covered %0d input bytes and %0d result beats: %0d frames ok, %0d error endings",
             sb.bytes_taken, sb.beats_checked, sb.frames_delivered, sb.error_endings);
    $display("max_payload went through 1518, 2047, 0, %0d; one long output stall",
             small_cap);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
